// ----- rtl/core/timespec_quantum_converter_defines.svh -----
// ----------------------------------------------------------------------------
// Timespec quantum converter assertion macros
// Shared concurrent check forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef TIMESPEC_QUANTUM_CONVERTER_DEFINES_SVH
`define TIMESPEC_QUANTUM_CONVERTER_DEFINES_SVH

// same-cycle implication
`define TQC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication
`define TQC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ----- rtl/core/tqc_pkg.sv -----
// ----------------------------------------------------------------------------
// tqc_pkg
// Types and constants shared by the timespec quantum converter.
// ----------------------------------------------------------------------------
package tqc_pkg;

  localparam int QLEN_W = 30;
  localparam int DVD_W  = 61;   // widest dividend: 2^31 * (2^30 - 1) < 2^61
  localparam int QUO_W  = 32;   // quotient bits kept; higher ones fold into ovf
  localparam int REM_W  = 30;

  localparam logic [QLEN_W-1:0] NS_PER_SEC    = 30'd1000000000;
  localparam logic [QLEN_W-1:0] QLEN_RESET    = 30'd1000000;
  localparam logic [31:0]       QUANTA_MAX    = 32'h7fff_ffff;

  localparam logic OP_TO_QUANTA   = 1'b0;
  localparam logic OP_TO_INTERVAL = 1'b1;

  localparam logic [1:0] RND_ZERO = 2'd0;
  localparam logic [1:0] RND_AWAY = 2'd1;

  typedef struct packed {
    logic              valid;
    logic              op;
    logic              bad;
    logic              up;
    logic              neg;
    logic [DVD_W-1:0]  dvd;
    logic [REM_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
    logic              ovf;
  } cell_t;

endpackage

// ----- rtl/core/tqc_cell.sv -----
// ----------------------------------------------------------------------------
// tqc_cell
// One restoring-division step: takes the next dividend bit, yields one
// quotient bit, and passes the item on to the next cell.
// ----------------------------------------------------------------------------
module tqc_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic [tqc_pkg::QLEN_W-1:0] quantum_len,
  input  tqc_pkg::cell_t             cell_in,
  output tqc_pkg::cell_t             cell_out
);
  import tqc_pkg::*;

  logic [QLEN_W-1:0] dsr;
  logic [REM_W:0]    trial;
  logic [REM_W+1:0]  diff;
  logic              qbit;
  cell_t             cell_next;

  always_comb begin
    dsr   = (cell_in.op == OP_TO_INTERVAL) ? NS_PER_SEC : quantum_len;
    trial = {cell_in.rem, cell_in.dvd[DVD_W-1]};
    diff  = {1'b0, trial} - {2'b00, dsr};
    qbit  = ~diff[REM_W+1];
    cell_next       = cell_in;
    cell_next.dvd   = {cell_in.dvd[DVD_W-2:0], 1'b0};
    // zero divisor truncates the 31-bit trial; the result saturates later
    cell_next.rem   = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
    cell_next.quo   = {cell_in.quo[QUO_W-2:0], qbit};
    cell_next.ovf   = cell_in.ovf | cell_in.quo[QUO_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (adv) begin
      cell_out.valid <= cell_next.valid;
    end
    if (adv) begin
      cell_out.op  <= cell_next.op;
      cell_out.bad <= cell_next.bad;
      cell_out.up  <= cell_next.up;
      cell_out.neg <= cell_next.neg;
      cell_out.dvd <= cell_next.dvd;
      cell_out.rem <= cell_next.rem;
      cell_out.quo <= cell_next.quo;
      cell_out.ovf <= cell_next.ovf;
    end
  end

endmodule

// ----- rtl/core/timespec_quantum_converter.sv -----
// ----------------------------------------------------------------------------
// timespec_quantum_converter
// Interval <-> scheduler quanta conversion through a row of division cells.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while the output is not stalled and passes each
// through a register for the operands, one for the 32x30 multiply, one for
// the nanosecond add, 61 division cells (one quotient bit each), and the
// output register. The whole pipeline holds while a result waits on m_tready.
// Direction 0 divides by quantum_len, direction 1 by one billion, in the same
// cells. quantum_len is written through cfg_* and must change only while idle.
`include "timespec_quantum_converter_defines.svh"

module timespec_quantum_converter (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [29:0]  cfg_data,     // quantum_length_ns
  input  logic         s_tvalid,
  output logic         s_tready,
  // interval_seconds[30:0], interval_nanoseconds[60:31], rounding_mode[62:61],
  // quanta_count[94:63], zero fill
  input  logic [95:0]  s_tdata,
  input  logic         s_tuser,      // operation
  output logic         m_tvalid,
  input  logic         m_tready,
  // quanta_result[31:0], result_seconds[64:32], result_nanoseconds[95:65],
  // bad_rounding[96], zero fill
  output logic [103:0] m_tdata
);
  import tqc_pkg::*;

  logic              adv;
  logic [QLEN_W-1:0] quantum_len;

  logic [30:0] in_secs;
  logic [29:0] in_nsec;
  logic [1:0]  in_mode;
  logic [31:0] in_cnt;
  logic        in_op;
  logic [31:0] in_mag;

  logic              v1, op1, bad1, up1, neg1;
  logic [31:0]       a1;
  logic [QLEN_W-1:0] b1, add1;
  logic              v2, op2, bad2, up2, neg2;
  logic [61:0]       prod2;
  logic [QLEN_W-1:0] add2;
  cell_t             head;
  cell_t             chain [0:DVD_W];
  cell_t             tail;

  logic [31:0] qsum;
  logic [31:0] fin_quanta;
  logic [32:0] fin_secs;
  logic [30:0] fin_ns;

  assign adv       = ~m_tvalid | m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_len <= QLEN_RESET;
    end else if (cfg_valid) begin
      quantum_len <= cfg_data;
    end
  end

  assign in_secs = s_tdata[30:0];
  assign in_nsec = s_tdata[60:31];
  assign in_mode = s_tdata[62:61];
  assign in_cnt  = s_tdata[94:63];
  assign in_op   = s_tuser;
  assign in_mag  = in_cnt[31] ? (32'd0 - in_cnt) : in_cnt;

  // operand stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
    if (adv) begin
      op1  <= in_op;
      bad1 <= (in_op == OP_TO_QUANTA) & in_mode[1];
      up1  <= (in_mode == RND_AWAY);
      neg1 <= (in_op == OP_TO_INTERVAL) & in_cnt[31];
      a1   <= (in_op == OP_TO_INTERVAL) ? in_mag : {1'b0, in_secs};
      b1   <= (in_op == OP_TO_INTERVAL) ? quantum_len : NS_PER_SEC;
      add1 <= (in_op == OP_TO_INTERVAL) ? '0 : in_nsec;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      op2   <= op1;
      bad2  <= bad1;
      up2   <= up1;
      neg2  <= neg1;
      prod2 <= {30'd0, a1} * {32'd0, b1};
      add2  <= add1;
    end
  end

  // add stage, feeds the cell row
  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (adv) begin
      head.valid <= v2;
    end
    if (adv) begin
      head.op  <= op2;
      head.bad <= bad2;
      head.up  <= up2;
      head.neg <= neg2;
      head.dvd <= DVD_W'(prod2 + {32'd0, add2});
      head.rem <= '0;
      head.quo <= '0;
      head.ovf <= 1'b0;
    end
  end

  assign chain[0] = head;

  for (genvar i = 0; i < DVD_W; i++) begin : g_cell
    tqc_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .adv         (adv),
      .quantum_len (quantum_len),
      .cell_in     (chain[i]),
      .cell_out    (chain[i+1])
    );
  end

  assign tail = chain[DVD_W];

  always_comb begin
    qsum       = {1'b0, tail.quo[30:0]} + {31'd0, tail.up & (tail.rem != '0)};
    fin_quanta = '0;
    fin_secs   = '0;
    fin_ns     = '0;
    if (tail.op == OP_TO_INTERVAL) begin
      fin_secs = tail.neg ? (33'd0 - {1'b0, tail.quo}) : {1'b0, tail.quo};
      fin_ns   = tail.neg ? (31'd0 - {1'b0, tail.rem}) : {1'b0, tail.rem};
    end else if (!tail.bad) begin
      fin_quanta = (tail.ovf | tail.quo[31] | qsum[31]) ? QUANTA_MAX : qsum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= tail.valid;
    end
    if (adv) begin
      m_tdata <= {7'd0, tail.bad & (tail.op == OP_TO_QUANTA), fin_ns, fin_secs,
                  fin_quanta};
    end
  end

  `TQC_ASSERT_NOW(a_quanta_nonneg, m_tvalid, !m_tdata[31])
  `TQC_ASSERT_NOW(a_bad_zeroes, m_tvalid && m_tdata[96], m_tdata[95:0] == '0)
  `TQC_ASSERT_NOW(a_ns_range, m_tvalid,
    !m_tdata[95] ? (m_tdata[95:65] < 31'd1000000000)
                 : (m_tdata[95:65] > 31'h4465_3600))
  `TQC_ASSERT_NEXT(a_tail_delivered, tail.valid && adv, m_tvalid)

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// Timespec quantum converter testbench
// Drives interval and quanta conversions through the stream ports, predicts
// each result from the quantum length in force, and compares field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tqc_pkg::*;

  localparam int PIPE_LAT  = 70;
  localparam int STALL_MAX = 200000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [29:0]   cfg_data = '0;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [95:0]   s_tdata = '0;
  logic          s_tuser = 1'b0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [103:0]  m_tdata;

  typedef struct packed {
    logic         bad;
    logic [30:0]  nsec;
    logic [32:0]  secs;
    logic [31:0]  quanta;
  } conv_result_t;

  conv_result_t  pending_results[$];
  logic [29:0]   quantum_len;
  int            errors = 0;
  int            n_sent = 0;
  int            n_checked = 0;
  int            idle_cycles = 0;
  int            burst_left = 0;
  bit            rx_random = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  timespec_quantum_converter u_top (.*);

  function automatic conv_result_t convert(logic op, logic [30:0] secs, logic [29:0] nsec,
                                           logic [1:0] mode, logic [31:0] qcnt);
    conv_result_t r;
    logic [63:0] total;
    logic [63:0] quot;
    longint prod;
    longint s;
    r = '0;
    if (op == OP_TO_QUANTA) begin
      if (mode != RND_ZERO && mode != RND_AWAY) begin
        r.bad = 1'b1;
        return r;
      end
      total = 64'(secs) * 64'd1000000000 + 64'(nsec);
      if (quantum_len == 0) quot = 64'(QUANTA_MAX);
      else begin
        quot = total / 64'(quantum_len);
        if (mode == RND_AWAY && (total % 64'(quantum_len)) != 0) quot++;
      end
      if (quot > 64'(QUANTA_MAX)) quot = 64'(QUANTA_MAX);
      r.quanta = quot[31:0];
    end else begin
      prod = longint'($signed(qcnt)) * longint'(quantum_len);
      s = prod / 64'sd1000000000;
      r.secs = s[32:0];
      r.nsec = 31'(prod - s * 64'sd1000000000);
    end
    return r;
  endfunction

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
        pending_results.size() == 0 && !s_tvalid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (!rx_random) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 7) < 5) || ($time % 300 < 40);
  end

  // result checker
  always @(posedge clk) begin
    conv_result_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[96:0];
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        n_checked++;
        if (got.quanta !== exp_r.quanta) begin
          $display("%0t quanta_result exp %h got %h", $time, exp_r.quanta, got.quanta);
          errors++;
        end
        if (got.secs !== exp_r.secs) begin
          $display("%0t result_seconds exp %h got %h", $time, exp_r.secs, got.secs);
          errors++;
        end
        if (got.nsec !== exp_r.nsec) begin
          $display("%0t result_nanoseconds exp %h got %h", $time, exp_r.nsec, got.nsec);
          errors++;
        end
        if (got.bad !== exp_r.bad) begin
          $display("%0t bad_rounding exp %b got %b", $time, exp_r.bad, got.bad);
          errors++;
        end
      end
    end
  end

  task automatic send_beat(logic op, logic [30:0] secs, logic [29:0] nsec,
                           logic [1:0] mode, logic [31:0] qcnt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, qcnt, mode, nsec, secs};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(convert(op, secs, nsec, mode, qcnt));
    n_sent++;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic write_quantum(logic [29:0] len);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    quantum_len = len;
    @(posedge clk);
  endtask

  task automatic test_directed;
    send_beat(OP_TO_QUANTA, 31'h7fffffff, 30'd999999999, RND_ZERO, '0);
    send_beat(OP_TO_QUANTA, 31'h7fffffff, 30'h3fffffff, RND_AWAY, '1);
    send_beat(OP_TO_QUANTA, 0, 0, RND_AWAY, '0);
    send_beat(OP_TO_QUANTA, 0, 1, RND_AWAY, '0);
    send_beat(OP_TO_QUANTA, 0, 1, RND_ZERO, '0);
    send_beat(OP_TO_QUANTA, 2, 30'd999999, RND_AWAY, '0);
    send_beat(OP_TO_QUANTA, 5, 7, 2'd2, '0);
    send_beat(OP_TO_QUANTA, 5, 7, 2'd3, '0);
    send_beat(OP_TO_INTERVAL, '1, '1, 2'd3, 32'h7fffffff);
    send_beat(OP_TO_INTERVAL, 0, 0, RND_ZERO, 32'h80000000);
    send_beat(OP_TO_INTERVAL, 0, 0, RND_ZERO, 32'hffffffff);
    send_beat(OP_TO_INTERVAL, 0, 0, RND_ZERO, 32'd0);
    send_beat(OP_TO_INTERVAL, 0, 0, RND_AWAY, 32'd1001);
  endtask

  task automatic test_random(int n);
    logic [1:0] mode;
    logic [30:0] secs;
    logic [29:0] nsec;
    for (int i = 0; i < n; i++) begin
      mode = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: secs = 31'($urandom);
        1: secs = 31'($urandom_range(0, 1000));
        default: secs = 31'($urandom_range(0, 5));
      endcase
      nsec = ($urandom_range(0, 7) == 0) ? 30'($urandom) : 30'($urandom_range(0, 999999999));
      send_beat(1'($urandom), secs, nsec, mode, $urandom);
    end
  endtask

  initial begin
    logic [29:0] lens[6];
    lens = '{30'd1000000, 30'd1, 30'h3fffffff, 30'd0, 30'd1000000000, 30'd7};
    quantum_len = QLEN_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    for (int k = 1; k < 6; k++) begin
      write_quantum(lens[k]);
      test_directed();
    end
    for (int k = 0; k < 8; k++) begin
      write_quantum((k < 6) ? lens[k] : 30'($urandom));
      rx_random = (k != 3);
      test_random(150);
    end
    drain();
    $display("Sent %0d conversions over 14 quantum lengths, %0d results checked.",
             n_sent, n_checked);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
